// ===== src/ure_pkg.sv =====
// shared types and constants for the ultrasonic echo ranger
// no dependencies; compiled first
`default_nettype none

package ure_pkg;

    localparam int TICKS_W = 32;
    localparam int OVF_W   = 9;
    localparam int DIST_W  = 16;
    localparam int CAP_W   = 16;
    localparam int SCALE_W = 17;
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = TICKS_W + SCALE_W;
    localparam int SCALED_W = PROD_W - FRAC_W;

    localparam logic [SCALE_W-1:0] SCALE_Q16 = 17'd72561;

    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_TICK    = 2'd1;
    localparam logic [1:0] OP_CAPTURE = 2'd2;

    localparam logic [1:0] REG_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_MAX     = 2'd1;
    localparam logic [1:0] REG_MIN     = 2'd2;
    localparam logic [1:0] REG_LED     = 2'd3;

    localparam logic [7:0]        RST_TIMEOUT = 8'd1;
    localparam logic [DIST_W-1:0] RST_MAX     = 16'd25600;
    localparam logic [DIST_W-1:0] RST_MIN     = 16'd128;
    localparam logic [DIST_W-1:0] RST_LED     = 16'd1280;

    typedef struct packed {
        logic [7:0]        timeout_overflows;
        logic [DIST_W-1:0] max_distance;
        logic [DIST_W-1:0] min_distance;
        logic [DIST_W-1:0] led_threshold;
    } cfg_t;

    typedef struct packed {
        logic               timeout;
        logic [TICKS_W-1:0] ticks;
    } stage_t;

endpackage

`default_nettype wire

// ===== src/ure_ifs.sv =====
// valid/ready channels for timer events and range results
// depends on nothing beyond the language
`default_nettype none

interface ure_event_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [15:0] capture_count;
    logic        echo_level;

    modport source (output valid, output opcode, output capture_count,
                    output echo_level, input ready);
    modport sink (input valid, input opcode, input capture_count,
                  input echo_level, output ready);
endinterface

interface ure_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] distance;
    logic        timed_out;
    logic        led_on;

    modport source (output valid, output distance, output timed_out,
                    output led_on, input ready);
    modport sink (input valid, input distance, input timed_out,
                  input led_on, output ready);
endinterface

`default_nettype wire

// ===== src/ure_regs.sv =====
// apb configuration registers for the echo ranger
// depends on ure_pkg
`default_nettype none

module ure_regs
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output ure_pkg::cfg_t    cfg
);

    ure_pkg::cfg_t cfg_reg;
    ure_pkg::cfg_t cfg_next;
    logic [1:0]    idx;
    logic          wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[3:2];
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                ure_pkg::REG_TIMEOUT: cfg_next.timeout_overflows = pwdata[7:0];
                ure_pkg::REG_MAX:     cfg_next.max_distance      = pwdata[15:0];
                ure_pkg::REG_MIN:     cfg_next.min_distance      = pwdata[15:0];
                ure_pkg::REG_LED:     cfg_next.led_threshold     = pwdata[15:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            ure_pkg::REG_TIMEOUT: prdata = {24'd0, cfg_reg.timeout_overflows};
            ure_pkg::REG_MAX:     prdata = {16'd0, cfg_reg.max_distance};
            ure_pkg::REG_MIN:     prdata = {16'd0, cfg_reg.min_distance};
            ure_pkg::REG_LED:     prdata = {16'd0, cfg_reg.led_threshold};
            default:              prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_overflows <= ure_pkg::RST_TIMEOUT;
            cfg_reg.max_distance      <= ure_pkg::RST_MAX;
            cfg_reg.min_distance      <= ure_pkg::RST_MIN;
            cfg_reg.led_threshold     <= ure_pkg::RST_LED;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/ure_track.sv =====
// event tracking stage: overflow count, rising capture, pulse width in ticks
// depends on ure_pkg and ure_event_if
`default_nettype none

module ure_track
#(
    parameter int TIMER_PERIOD_BITS = 16
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  ure_pkg::cfg_t   cfg,
    ure_event_if.sink       evt,
    input  wire logic       s1_take,
    output logic            s1_valid,
    output ure_pkg::stage_t s1_data
);

    logic [ure_pkg::OVF_W-1:0]   ovf_reg;
    logic [ure_pkg::OVF_W-1:0]   ovf_next;
    logic [ure_pkg::OVF_W-1:0]   ovf_inc;
    logic [ure_pkg::CAP_W-1:0]   rise_reg;
    logic [ure_pkg::CAP_W-1:0]   rise_next;
    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    ure_pkg::stage_t             s1_data_reg;
    ure_pkg::stage_t             s1_data_next;
    logic                        acc;
    logic                        emit;
    logic [ure_pkg::TICKS_W-1:0] ticks;

    assign evt.ready = !s1_valid_reg || s1_take;
    assign acc       = evt.valid && evt.ready;
    assign s1_valid  = s1_valid_reg;
    assign s1_data   = s1_data_reg;
    assign ovf_inc   = ovf_reg + 1'b1;

    // pulse width, wrapping at the ticks width
    assign ticks = (ure_pkg::TICKS_W'(ovf_reg) << TIMER_PERIOD_BITS)
                 + ure_pkg::TICKS_W'(evt.capture_count)
                 - ure_pkg::TICKS_W'(rise_reg);

    always_comb
    begin
        emit         = 1'b0;
        ovf_next     = ovf_reg;
        rise_next    = rise_reg;
        s1_data_next = s1_data_reg;
        case (evt.opcode)
            ure_pkg::OP_START:
            begin
                ovf_next = '0;
            end
            ure_pkg::OP_TICK:
            begin
                if (ovf_inc > {1'b0, cfg.timeout_overflows})
                begin
                    ovf_next             = '0;
                    emit                 = 1'b1;
                    s1_data_next.timeout = 1'b1;
                    s1_data_next.ticks   = '0;
                end
                else
                begin
                    ovf_next = ovf_inc;
                end
            end
            ure_pkg::OP_CAPTURE:
            begin
                if (evt.echo_level)
                begin
                    rise_next = evt.capture_count;
                    ovf_next  = '0;
                end
                else
                begin
                    emit                 = 1'b1;
                    s1_data_next.timeout = 1'b0;
                    s1_data_next.ticks   = ticks;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase

        if (acc)
            s1_valid_next = emit;
        else if (s1_take)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovf_reg      <= '0;
            rise_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (acc)
            begin
                ovf_reg  <= ovf_next;
                rise_reg <= rise_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc && emit)
            s1_data_reg <= s1_data_next;
    end

endmodule

`default_nettype wire

// ===== src/ure_scale.sv =====
// scaling stage: ticks to 1/64 cm, clamping, led state, result register
// depends on ure_pkg and ure_result_if
`default_nettype none

module ure_scale
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  ure_pkg::cfg_t   cfg,
    input  wire logic       s1_valid,
    input  ure_pkg::stage_t s1_data,
    output logic            s1_take,
    ure_result_if.source    res
);

    logic [ure_pkg::PROD_W-1:0]   prod;
    logic [ure_pkg::SCALED_W-1:0] scaled;
    logic [ure_pkg::DIST_W-1:0]   dist_calc;
    logic                         led_calc;
    logic                         led_reg;
    logic                         led_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [ure_pkg::DIST_W-1:0]   dist_reg;
    logic [ure_pkg::DIST_W-1:0]   dist_next;
    logic                         tmo_reg;

    assign s1_take = s1_valid && (!out_valid_reg || res.ready);

    assign prod   = ure_pkg::PROD_W'(s1_data.ticks) * ure_pkg::PROD_W'(ure_pkg::SCALE_Q16);
    assign scaled = prod[ure_pkg::PROD_W-1:ure_pkg::FRAC_W];

    always_comb
    begin
        if (scaled > ure_pkg::SCALED_W'(cfg.max_distance))
            dist_calc = cfg.max_distance;
        else if (scaled < ure_pkg::SCALED_W'(cfg.min_distance))
            dist_calc = '0;
        else
            dist_calc = scaled[ure_pkg::DIST_W-1:0];

        led_calc = dist_calc < cfg.led_threshold;

        if (s1_data.timeout)
        begin
            dist_next = '0;
            led_next  = led_reg;
        end
        else
        begin
            dist_next = dist_calc;
            led_next  = led_calc;
        end

        if (s1_take)
            out_valid_next = 1'b1;
        else if (res.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            led_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (s1_take)
                led_reg <= led_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_take)
        begin
            dist_reg <= dist_next;
            tmo_reg  <= s1_data.timeout;
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.distance  = dist_reg;
    assign res.timed_out = tmo_reg;
    assign res.led_on    = led_reg;

endmodule

`default_nettype wire

// ===== src/ultrasonic_echo_ranger.sv =====
// ultrasonic echo ranger top level: apb registers, event tracking, scaling
// depends on ure_pkg, ure_ifs, ure_regs, ure_track, ure_scale
//
// timer_evt carries one timer event per item: start, overflow tick, or edge
// capture with the latched timer value and echo level. range_res carries one
// result item for each falling-edge capture and for each overflow timeout;
// other events only update internal state and give no result.
// an event is accepted on any cycle ready is high; ready stays high as long
// as the result register drains, so one item per cycle is sustained.
// a result on its way to range_res passes the tick register, loaded at the
// edge that accepts its event, and then the result register behind the
// multiply and clamp stage.
// when range_res stalls, one result waits in the result register and one in
// the tick register; ready drops only once both are full.
// reset clears the overflow count, the rising capture, the led and all
// valid flags, and loads the register defaults (timeout 1, max 25600,
// min 128, led threshold 1280). registers sit at byte addresses 0, 4, 8, 12.
`default_nettype none

module ultrasonic_echo_ranger
#(
    parameter int TIMER_PERIOD_BITS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    ure_event_if.sink        timer_evt,
    ure_result_if.source     range_res
);

    ure_pkg::cfg_t   cfg;
    logic            s1_take;
    logic            s1_valid;
    ure_pkg::stage_t s1_data;

    ure_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ure_track
    #(
        .TIMER_PERIOD_BITS (TIMER_PERIOD_BITS)
    )
    u_track
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .evt      (timer_evt),
        .s1_take  (s1_take),
        .s1_valid (s1_valid),
        .s1_data  (s1_data)
    );

    ure_scale u_scale
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .s1_valid (s1_valid),
        .s1_data  (s1_data),
        .s1_take  (s1_take),
        .res      (range_res)
    );

endmodule

`default_nettype wire
